// ===== hdl/sog_pkg.sv =====
// shared types and constants for the shuffled order generator
// no dependencies
package sog_pkg;

  localparam int ITEM_COUNT = 16;
  localparam int IDX_W      = $clog2(ITEM_COUNT);
  localparam int POS_W      = $clog2(ITEM_COUNT + 1);
  localparam int RAND_W     = 16;
  localparam int OUT_IDX_W  = 4;
  localparam int STEP_W     = $clog2(RAND_W + 1);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    FUNC_RESTART = 2'd0,
    FUNC_DRAW    = 2'd1,
    FUNC_NEXT    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

endpackage

// ===== hdl/sog_divider.sv =====
// iterative restoring remainder unit, one quotient bit per cycle
// depends on sog_pkg
module sog_divider
  import sog_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAND_W-1:0] dividend,
  input  logic [IDX_W:0]    divisor,
  output logic              done,
  output idx_t              remainder
);

  logic              busy_r,  busy_nxt;
  logic              done_r,  done_nxt;
  logic [STEP_W-1:0] cnt_r,   cnt_nxt;
  logic [RAND_W-1:0] dvd_r,   dvd_nxt;
  logic [IDX_W:0]    dsr_r,   dsr_nxt;
  logic [IDX_W:0]    rem_r,   rem_nxt;
  logic [IDX_W+1:0]  trial;

  // one shift and conditional subtract per step
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[RAND_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_W'(RAND_W);
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = (IDX_W+1)'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[IDX_W:0];
      end
      dvd_nxt = {dvd_r[RAND_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r[IDX_W-1:0];

endmodule

// ===== hdl/shuffled_order_generator.sv =====
// shuffled order generator: restart, next index, identity refill of ITEM_COUNT entries, and
// draw (the last draw adds a history check and may swap entries 0 and 1); draw time is
// set by the 16-step remainder unit and the single table read port
// one request at a time: ready only while idle, result held until taken
// synchronous active-low reset: order exhausted, no shuffle, no history;
// the order table itself is not cleared
module shuffled_order_generator
  import sog_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_func,
  input  logic [RAND_W-1:0]    in_rand_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_IDX_W-1:0] out_order_index,
  output logic                 out_index_valid,
  output logic                 out_need_draw
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_FILL   = 13'b0000000000010,
    S_DIV    = 13'b0000000000100,
    S_RD_B   = 13'b0000000001000,
    S_SWAP_A = 13'b0000000010000,
    S_SWAP_B = 13'b0000000100000,
    S_FIN_A  = 13'b0000001000000,
    S_FIN_B  = 13'b0000010000000,
    S_FIN_C  = 13'b0000100000000,
    S_FIN_D  = 13'b0001000000000,
    S_NEXT_A = 13'b0010000000000,
    S_NEXT_B = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  rp_r,    rp_nxt;
  idx_t              sp_r,    sp_nxt;
  logic              act_r,   act_nxt;
  idx_t              last_r,  last_nxt;
  logic              hl_r,    hl_nxt;
  idx_t              fc_r,    fc_nxt;
  idx_t              j_r,     j_nxt;
  idx_t              a_r,     a_nxt;
  idx_t              idx_r,   idx_nxt;
  logic              iv_r,    iv_nxt;

  idx_t              mem [ITEM_COUNT];
  idx_t              rdata_r;
  idx_t              raddr;
  idx_t              waddr;
  idx_t              wdata;
  logic              we;

  logic              div_start;
  logic              div_done;
  idx_t              div_rem;
  logic [IDX_W:0]    div_divisor;
  logic [IDX_W+3:0]  idx_ext;
  logic              accept;

  assign accept      = in_valid && in_ready;
  assign div_divisor = {1'b0, sp_r} + 1'b1;

  // shared remainder unit for rand_word mod (i+1)
  sog_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_rand_word),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    rp_nxt    = rp_r;
    sp_nxt    = sp_r;
    act_nxt   = act_r;
    last_nxt  = last_r;
    hl_nxt    = hl_r;
    fc_nxt    = fc_r;
    j_nxt     = j_r;
    a_nxt     = a_r;
    idx_nxt   = idx_r;
    iv_nxt    = iv_r;
    raddr     = sp_r;
    waddr     = fc_r;
    wdata     = fc_r;
    we        = 1'b0;
    div_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt   = '0;
          iv_nxt    = 1'b0;
          state_nxt = S_OUT;
          case (in_func)
            FUNC_RESTART: begin
              rp_nxt  = POS_W'(ITEM_COUNT);
              hl_nxt  = 1'b0;
              act_nxt = 1'b0;
            end
            FUNC_DRAW: begin
              if (act_r) begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
            FUNC_NEXT: begin
              if (!act_r) begin
                if (rp_r >= POS_W'(ITEM_COUNT)) begin
                  fc_nxt    = '0;
                  state_nxt = S_FILL;
                end else begin
                  state_nxt = S_NEXT_A;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      // identity refill, one entry a cycle
      S_FILL: begin
        we     = 1'b1;
        waddr  = fc_r;
        wdata  = fc_r;
        fc_nxt = fc_r + 1'b1;
        if (fc_r == IDX_W'(ITEM_COUNT - 1)) begin
          sp_nxt    = IDX_W'(ITEM_COUNT - 1);
          act_nxt   = 1'b1;
          state_nxt = S_OUT;
        end
      end
      // wait for partner index, keep reading entry i
      S_DIV: begin
        raddr = sp_r;
        if (div_done) begin
          j_nxt     = div_rem;
          state_nxt = S_RD_B;
        end
      end
      S_RD_B: begin
        raddr     = j_r;
        a_nxt     = rdata_r;
        state_nxt = S_SWAP_A;
      end
      S_SWAP_A: begin
        we        = 1'b1;
        waddr     = sp_r;
        wdata     = rdata_r;
        state_nxt = S_SWAP_B;
      end
      S_SWAP_B: begin
        we        = 1'b1;
        waddr     = j_r;
        wdata     = a_r;
        sp_nxt    = sp_r - 1'b1;
        state_nxt = S_OUT;
        if (sp_r == IDX_W'(1)) begin
          if (hl_r) begin
            state_nxt = S_FIN_A;
          end else begin
            rp_nxt  = '0;
            act_nxt = 1'b0;
          end
        end
      end
      // avoid repeating the last issued index across the pass boundary
      S_FIN_A: begin
        raddr     = '0;
        state_nxt = S_FIN_B;
      end
      S_FIN_B: begin
        raddr     = IDX_W'(1);
        a_nxt     = rdata_r;
        state_nxt = S_FIN_C;
      end
      S_FIN_C: begin
        if (a_r == last_r) begin
          we        = 1'b1;
          waddr     = '0;
          wdata     = rdata_r;
          state_nxt = S_FIN_D;
        end else begin
          rp_nxt    = '0;
          act_nxt   = 1'b0;
          state_nxt = S_OUT;
        end
      end
      S_FIN_D: begin
        we        = 1'b1;
        waddr     = IDX_W'(1);
        wdata     = a_r;
        rp_nxt    = '0;
        act_nxt   = 1'b0;
        state_nxt = S_OUT;
      end
      // issue the stored entry
      S_NEXT_A: begin
        raddr     = rp_r[IDX_W-1:0];
        state_nxt = S_NEXT_B;
      end
      S_NEXT_B: begin
        idx_nxt   = rdata_r;
        iv_nxt    = 1'b1;
        last_nxt  = rdata_r;
        hl_nxt    = 1'b1;
        rp_nxt    = rp_r + 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rp_r    <= POS_W'(ITEM_COUNT);
      sp_r    <= '0;
      act_r   <= 1'b0;
      last_r  <= '0;
      hl_r    <= 1'b0;
      iv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rp_r    <= rp_nxt;
      sp_r    <= sp_nxt;
      act_r   <= act_nxt;
      last_r  <= last_nxt;
      hl_r    <= hl_nxt;
      iv_r    <= iv_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    fc_r  <= fc_nxt;
    j_r   <= j_nxt;
    a_r   <= a_nxt;
    idx_r <= idx_nxt;
  end

  // order table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // outputs
  assign idx_ext         = {4'b0000, idx_r};
  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_order_index = idx_ext[OUT_IDX_W-1:0];
  assign out_index_valid = iv_r;
  assign out_need_draw   = act_r;

endmodule

// ===== bench/tb_shuffled_order_generator.sv =====
// self-checking bench for the shuffled order generator: directed table, then random requests
// depends on sog_pkg and shuffled_order_generator from hdl
module tb_shuffled_order_generator;
  import sog_pkg::*;

  // one result as the block reports it
  typedef struct packed {
    logic [OUT_IDX_W-1:0] index;
    logic                 valid;
    logic                 need_draw;
  } order_result_t;

  // one row of the directed table
  typedef struct packed {
    func_t             func;
    logic [RAND_W-1:0] word;
    logic              typed;
    order_result_t     want;
  } stim_row_t;

  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  localparam order_result_t SHUFFLE_PENDING = '{index: '0, valid: 1'b0, need_draw: 1'b1};
  localparam order_result_t ALL_ZERO        = '0;

  localparam int DIRECTED_ROWS  = 25;
  localparam int RANDOM_ITEMS   = 1025;
  localparam int MAX_ERROR_LINES = 100;

  // directed table: typed rows where the answer is obvious, the rest predicted
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{FUNC_NEXT,    16'h0000, TYPED,     SHUFFLE_PENDING}, // exhausted after reset: refill
    '{FUNC_NEXT,    16'hFFFF, TYPED,     SHUFFLE_PENDING}, // request while shuffling
    '{FUNC_NONE,    16'h0000, TYPED,     SHUFFLE_PENDING}, // unused selector shows shuffle
    '{FUNC_DRAW,    16'hFFFF, PREDICTED, ALL_ZERO},
    '{FUNC_DRAW,    16'h0000, PREDICTED, ALL_ZERO},
    '{FUNC_RESTART, 16'hFFFF, TYPED,     ALL_ZERO},        // restart abandons the shuffle
    '{FUNC_DRAW,    16'hAAAA, TYPED,     ALL_ZERO},        // draw while idle is ignored
    '{FUNC_NONE,    16'h5555, TYPED,     ALL_ZERO},
    '{FUNC_NEXT,    16'h0000, TYPED,     SHUFFLE_PENDING},
    '{FUNC_DRAW,    16'hFFFF, PREDICTED, ALL_ZERO},
    '{FUNC_DRAW,    16'h0000, PREDICTED, ALL_ZERO},
    '{FUNC_DRAW,    16'h8000, PREDICTED, ALL_ZERO},
    '{FUNC_DRAW,    16'h0001, PREDICTED, ALL_ZERO},
    '{FUNC_DRAW,    16'h7FFF, PREDICTED, ALL_ZERO},
    '{FUNC_DRAW,    16'hFFFE, PREDICTED, ALL_ZERO},
    '{FUNC_DRAW,    16'hAAAA, PREDICTED, ALL_ZERO},
    '{FUNC_DRAW,    16'h5555, PREDICTED, ALL_ZERO},
    '{FUNC_DRAW,    16'h1234, PREDICTED, ALL_ZERO},
    '{FUNC_DRAW,    16'h0F0F, PREDICTED, ALL_ZERO},
    '{FUNC_DRAW,    16'hF0F0, PREDICTED, ALL_ZERO},
    '{FUNC_DRAW,    16'h00FF, PREDICTED, ALL_ZERO},
    '{FUNC_DRAW,    16'hFF00, PREDICTED, ALL_ZERO},
    '{FUNC_DRAW,    16'hC3A5, PREDICTED, ALL_ZERO},
    '{FUNC_DRAW,    16'h0002, PREDICTED, ALL_ZERO},        // last swap ends the shuffle
    '{FUNC_NEXT,    16'h0000, PREDICTED, ALL_ZERO}         // first index of the pass
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_func;
  logic [RAND_W-1:0]    in_rand_word;
  logic                 out_valid;
  logic                 out_ready;
  logic [OUT_IDX_W-1:0] out_order_index;
  logic                 out_index_valid;
  logic                 out_need_draw;

  shuffled_order_generator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_rand_word    (in_rand_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_order_index (out_order_index),
    .out_index_valid (out_index_valid),
    .out_need_draw   (out_need_draw)
  );

  // predicted state of the generator
  idx_t             order_copy [ITEM_COUNT];
  logic [POS_W-1:0] next_read;
  idx_t             next_swap;
  logic             shuffling;
  idx_t             prev_index;
  logic             has_prev;
  logic             steer_pass;

  order_result_t expected_orders [$];
  int            error_count;
  int            results_seen;
  int            counted_items;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic report_error(input string msg);
    if (error_count < MAX_ERROR_LINES)
      $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // predicted effect of one request on the generator
  task automatic predict_order_result(input func_t f, input logic [RAND_W-1:0] w,
                                      output order_result_t r);
    idx_t j;
    idx_t t;
    r = '0;
    case (f)
      FUNC_RESTART: begin
        next_read = POS_W'(ITEM_COUNT);
        has_prev  = 1'b0;
        shuffling = 1'b0;
      end
      FUNC_DRAW: begin
        if (shuffling) begin
          j = idx_t'(int'(w) % (int'(next_swap) + 1));
          t = order_copy[next_swap];
          order_copy[next_swap] = order_copy[j];
          order_copy[j] = t;
          next_swap--;
          if (next_swap == 0) begin
            // keep the first index of the pass from repeating the last one
            if (has_prev && order_copy[0] == prev_index) begin
              t = order_copy[0];
              order_copy[0] = order_copy[1];
              order_copy[1] = t;
            end
            next_read = '0;
            shuffling = 1'b0;
          end
        end
      end
      FUNC_NEXT: begin
        if (!shuffling) begin
          if (next_read >= ITEM_COUNT) begin
            for (int i = 0; i < ITEM_COUNT; i++) order_copy[idx_t'(i)] = idx_t'(i);
            next_swap = idx_t'(ITEM_COUNT - 1);
            shuffling = 1'b1;
          end else begin
            r.index    = OUT_IDX_W'(order_copy[next_read[IDX_W-1:0]]);
            r.valid    = 1'b1;
            prev_index = order_copy[next_read[IDX_W-1:0]];
            has_prev   = 1'b1;
            next_read++;
          end
        end
      end
      default: ;
    endcase
    r.need_draw = shuffling;
  endtask

  // random word; on steered passes it herds the last issued index toward entry 0
  function automatic logic [RAND_W-1:0] pick_draw_word();
    int i;
    int k;
    int j;
    int span;
    i = int'(next_swap);
    k = -1;
    if (steer_pass && shuffling && has_prev) begin
      for (int p = 0; p <= i; p++) if (order_copy[idx_t'(p)] == prev_index) k = p;
      if (k >= 0) begin
        if (k == i) begin
          j = 0;
        end else begin
          j = $urandom_range(0, i - 1);
          if (j >= k) j++;
        end
        span = (65535 - j) / (i + 1);
        return RAND_W'(j + (i + 1) * int'($urandom_range(0, span)));
      end
    end
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return RAND_W'($urandom);
    endcase
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // offer one request and wait until the block takes it
  task automatic send_request(input func_t f, input logic [RAND_W-1:0] w,
                              input logic typed, input order_result_t want);
    order_result_t r;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_func      <= f;
    in_rand_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_order_result(f, w, r);
    expected_orders.push_back(typed ? want : r);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // stimulus
  initial begin
    func_t         f;
    logic [RAND_W-1:0] w;
    int            roll;
    logic          paused;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_func      = FUNC_NONE;
    in_rand_word = '0;
    for (int i = 0; i < ITEM_COUNT; i++) order_copy[idx_t'(i)] = '0;
    next_read     = POS_W'(ITEM_COUNT);
    next_swap     = '0;
    shuffling     = 1'b0;
    prev_index    = '0;
    has_prev      = 1'b0;
    steer_pass    = 1'b0;
    error_count   = 0;
    counted_items = 0;
    paused        = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_request(DIRECTED[r].func, DIRECTED[r].word, DIRECTED[r].typed, DIRECTED[r].want);
      idle_sender(pick_gap());
    end

    // random part: mostly full passes, some noise and cut passes
    while (counted_items < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (shuffling) begin
        if (roll < 90)      f = FUNC_DRAW;
        else if (roll < 94) f = FUNC_NEXT;
        else if (roll < 97) f = FUNC_NONE;
        else                f = FUNC_RESTART;
      end else begin
        if (roll < 90)      f = FUNC_NEXT;
        else if (roll < 92) f = FUNC_RESTART;
        else if (roll < 96) f = FUNC_DRAW;
        else                f = FUNC_NONE;
        if (f == FUNC_NEXT && next_read >= ITEM_COUNT)
          steer_pass = ($urandom_range(0, 2) == 0);
      end
      w = pick_draw_word();
      send_request(f, w, PREDICTED, ALL_ZERO);
      counted_items++;

      // pause until the block has drained once
      if (!paused && counted_items >= 500) begin
        paused = 1'b1;
        idle_sender(1);
        while (expected_orders.size() != 0) @(posedge clk);
      end

      // back-to-back stretch
      if (counted_items < 300 || counted_items >= 400) idle_sender(pick_gap());
    end

    // drain and finish
    idle_sender(1);
    while (expected_orders.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0 && expected_orders.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // result side back-pressure, including one long hold while requests keep coming
  initial begin
    int   stall;
    int   pick;
    logic held;
    out_ready = 1'b0;
    stall     = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 200) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (results_seen >= 450 && results_seen < 550) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 70)      stall = 0;
        else if (pick < 92) stall = $urandom_range(1, 4);
        else                stall = $urandom_range(10, 40);
      end
    end
  end

  // compare each result with the oldest expectation
  initial results_seen = 0;
  always @(posedge clk) begin
    order_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_orders.size() == 0) begin
        report_error("result with no request outstanding");
      end else begin
        want = expected_orders.pop_front();
        if (out_order_index !== want.index)
          report_error($sformatf("order_index got %0d want %0d", out_order_index, want.index));
        if (out_index_valid !== want.valid)
          report_error($sformatf("index_valid got %b want %b", out_index_valid, want.valid));
        if (out_need_draw !== want.need_draw)
          report_error($sformatf("need_draw got %b want %b", out_need_draw, want.need_draw));
      end
    end
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("ERROR: timeout with %0d results outstanding", expected_orders.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
